/* hw/rtl/cbra_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the contiguous bitmap region allocator.
// Used by the allocator core, its scan submodule and its port checker; no dependencies.
package cbra_pkg;

  localparam int ADDR_W    = 48;
  localparam int PAGE_W    = 20;
  localparam int RIU_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam int WORD_W  = 32;
  localparam int WORD_AW = $clog2(WORD_W);

  localparam int REGION_SLOTS_DEF     = 1024;
  localparam int PAGES_PER_REGION_DEF = 512;
  localparam int PAGE_BYTES           = 4096;

  localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 48'h0100_0000_0000;
  localparam logic [RIU_W-1:0]  REGIONS_RESET   = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGIONS_IN_USE = 1'd1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_RUN = 1'b1;

  typedef struct packed {
    logic               found;
    logic [WORD_AW-1:0] pos;
  } scan_hit_t;

endpackage

/* hw/rtl/contiguous_bitmap_region_allocator_core.sv */
`timescale 1ns / 1ps
// Top level of the first-fit contiguous region allocator: sequencer, bitmap RAM, divider and scan.
// Depends on cbra_pkg, cbra_ram, cbra_div and cbra_scan.
//
//   channel  handshake                 payload
//   req      req_valid / req_stall     action, page_count, free_address
//   rsp      rsp_valid / rsp_stall     region_address, status
//   cfg      cfg_write                 cfg_index, cfg_data
//
// The bitmap is held 32 regions to a RAM word; one item is worked on at a time.
// Allocate: the page count is divided into a region count, words are read to the first fit,
// the run is marked and its address formed by a multiply and an add; if no run fits, a failure
// status is returned. Free: the address offset is divided and the run's words are cleared.
// An item settled without the bitmap goes straight to the result. After reset a clearing pass
// writes every word, with req_stall high. A stalled result is held in the output register.
module contiguous_bitmap_region_allocator_core #(
  parameter int REGION_SLOTS     = cbra_pkg::REGION_SLOTS_DEF,
  parameter int PAGES_PER_REGION = cbra_pkg::PAGES_PER_REGION_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [cbra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbra_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             action,
  input  logic [cbra_pkg::PAGE_W-1:0]      page_count,
  input  logic [cbra_pkg::ADDR_W-1:0]      free_address,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [cbra_pkg::ADDR_W-1:0]      region_address,
  output logic                             status
);

  localparam int AWD       = cbra_pkg::ADDR_W;
  localparam int WAW       = cbra_pkg::WORD_AW;
  localparam int NUM_WORDS = (REGION_SLOTS + cbra_pkg::WORD_W - 1) / cbra_pkg::WORD_W;
  localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
  localparam int GW        = AW + WAW;
  localparam int CNT_W     = $clog2(REGION_SLOTS + 2);
  localparam int LIM_W     = $clog2(REGION_SLOTS + 1);
  localparam int RUN_W     = CNT_W + WAW + 1;
  localparam int MW        = (GW > CNT_W ? GW : CNT_W) + 1;
  localparam int LW        = LIM_W > cbra_pkg::RIU_W ? LIM_W : cbra_pkg::RIU_W;
  localparam int PG_SH     = $clog2(cbra_pkg::PAGE_BYTES);
  localparam int SPAN_W    = $clog2(REGION_SLOTS * PAGES_PER_REGION);
  localparam int XB        = SPAN_W > cbra_pkg::PAGE_W ? SPAN_W : cbra_pkg::PAGE_W;

  localparam logic [63:0] REGION_BYTES = 64'(PAGES_PER_REGION) * 64'(cbra_pkg::PAGE_BYTES);
  localparam logic [63:0] FREE_SPAN    = 64'(REGION_SLOTS) * REGION_BYTES;
  localparam logic [63:0] PAGE_SAT     = 64'(REGION_SLOTS + 1) * 64'(PAGES_PER_REGION);
  localparam int          RB_W         = $clog2(REGION_BYTES + 64'd1);
  localparam int          PW           = GW + RB_W;
  localparam logic [CNT_W-1:0] K_SAT   = CNT_W'(REGION_SLOTS + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVK  = 4'd2;
  localparam logic [3:0] S_DIVS  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_MARK  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                state;
  logic [AW-1:0]             clr_ptr;
  logic [AWD-1:0]            pool_base;
  logic [cbra_pkg::RIU_W-1:0] regions_in_use;

  logic                      action_q;
  logic                      page_sat_q;
  logic [AWD-1:0]            addr_q;
  logic [LIM_W-1:0]          limit_q;
  logic [CNT_W-1:0]          k;
  logic [AW-1:0]             ptr;
  logic                      rd_more;
  logic                      pend;
  logic [AW-1:0]             pend_w;
  logic [AW-1:0]             last_w;
  logic [RUN_W-1:0]          run;
  logic [GW-1:0]             lo;
  logic [GW-1:0]             hi;
  logic                      set_mode;
  logic [PW-1:0]             prod;
  logic [AWD-1:0]            res_addr;
  logic                      res_status;

  logic                      accept;
  logic                      page_sat_in;
  logic [LW-1:0]             ru_ext;
  logic [LIM_W-1:0]          limit_in;
  logic                      div_start;
  logic [XB-1:0]             div_dividend;
  logic                      div_done;
  logic [CNT_W-1:0]          div_q;
  logic                      k_ready;
  logic [CNT_W-1:0]          k_val;
  logic [AWD-1:0]            diff;
  logic [AWD-PG_SH-1:0]      diff_pages;
  logic                      in_pool;
  logic                      in_range;
  logic                      free_go;
  logic [MW-1:0]             limit_m1;
  logic [WAW-1:0]            lim_bit;
  logic [cbra_pkg::WORD_W-1:0] ram_rdata;
  logic [cbra_pkg::WORD_W-1:0] scan_word;
  logic [cbra_pkg::WORD_W-1:0] mod_word;
  cbra_pkg::scan_hit_t       hit;
  logic [RUN_W-1:0]          run_out;
  logic [GW-1:0]             hit_end;
  logic [GW-1:0]             hit_start;
  logic [MW-1:0]             free_end;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [cbra_pkg::WORD_W-1:0] ram_wdata;
  logic                      ram_re;

  assign req_stall   = state != S_IDLE;
  assign accept      = req_valid && !req_stall;
  assign page_sat_in = 64'(page_count) >= PAGE_SAT;
  assign ru_ext      = LW'(regions_in_use);
  assign limit_in    = (ru_ext < LW'(REGION_SLOTS)) ? LIM_W'(ru_ext) : LIM_W'(REGION_SLOTS);

  assign diff       = addr_q - pool_base;
  assign diff_pages = diff[AWD-1:PG_SH];
  assign in_pool    = addr_q >= pool_base;
  assign in_range   = 64'(diff) < FREE_SPAN;

  assign k_ready = (state == S_DIVK) && (page_sat_q || div_done);
  assign k_val   = page_sat_q ? K_SAT : ((div_q == '0) ? CNT_W'(1) : div_q);
  assign free_go = k_ready && (action_q == cbra_pkg::ACT_FREE) && in_pool && in_range;

  assign div_start    = (accept && !page_sat_in) || free_go;
  assign div_dividend = (state == S_IDLE) ? XB'(page_count) : XB'(diff_pages);

  cbra_div #(
    .DW      (XB),
    .QW      (CNT_W),
    .DIVISOR (PAGES_PER_REGION)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_q)
  );

  assign limit_m1 = MW'(limit_q) - MW'(1);
  assign lim_bit  = limit_m1[WAW-1:0];

  always_comb begin
    for (int j = 0; j < cbra_pkg::WORD_W; j++) begin
      scan_word[j] = ram_rdata[j] || ((pend_w == last_w) && (WAW'(j) > lim_bit));
      if (((pend_w != lo[GW-1:WAW]) || (WAW'(j) >= lo[WAW-1:0])) &&
          ((pend_w != hi[GW-1:WAW]) || (WAW'(j) <= hi[WAW-1:0]))) begin
        mod_word[j] = set_mode;
      end else begin
        mod_word[j] = ram_rdata[j];
      end
    end
  end

  cbra_scan #(
    .CNT_W (CNT_W),
    .RUN_W (RUN_W)
  ) u_scan (
    .word    (scan_word),
    .run_in  (run),
    .k       (k),
    .hit     (hit),
    .run_out (run_out)
  );

  assign hit_end   = {pend_w, hit.pos};
  assign hit_start = GW'(MW'(hit_end) + MW'(1) - MW'(k));
  assign free_end  = MW'(div_q) + MW'(k) - MW'(1);

  assign ram_we    = (state == S_CLEAR) || ((state == S_MARK) && pend);
  assign ram_waddr = (state == S_CLEAR) ? clr_ptr : pend_w;
  assign ram_wdata = (state == S_CLEAR) ? '0 : mod_word;
  assign ram_re    = rd_more && ((state == S_SCAN) || (state == S_MARK));

  cbra_ram #(
    .WIDTH (cbra_pkg::WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base      <= cbra_pkg::POOL_BASE_RESET;
      regions_in_use <= cbra_pkg::REGIONS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cbra_pkg::REG_POOL_BASE: begin
          pool_base <= cfg_data;
        end
        cbra_pkg::REG_REGIONS_IN_USE: begin
          regions_in_use <= cfg_data[cbra_pkg::RIU_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      rd_more   <= 1'b0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_ptr == AW'(NUM_WORDS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_ptr <= clr_ptr + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            action_q   <= action;
            page_sat_q <= page_sat_in;
            addr_q     <= free_address;
            limit_q    <= limit_in;
            state      <= S_DIVK;
          end
        end
        S_DIVK: begin
          if (k_ready) begin
            k          <= k_val;
            res_addr   <= '0;
            res_status <= cbra_pkg::STATUS_OK;
            if (action_q == cbra_pkg::ACT_ALLOC) begin
              if ((limit_q == '0) || (MW'(k_val) > MW'(limit_q))) begin
                res_status <= cbra_pkg::STATUS_NO_RUN;
                state      <= S_DONE;
              end else begin
                ptr     <= '0;
                rd_more <= 1'b1;
                pend    <= 1'b0;
                run     <= '0;
                last_w  <= AW'(limit_m1 >> WAW);
                state   <= S_SCAN;
              end
            end else if (free_go) begin
              state <= S_DIVS;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DIVS: begin
          if (div_done) begin
            lo       <= GW'(div_q);
            hi       <= (free_end >= MW'(REGION_SLOTS)) ? GW'(REGION_SLOTS - 1) : GW'(free_end);
            last_w   <= (free_end >= MW'(REGION_SLOTS)) ? AW'(NUM_WORDS - 1)
                                                        : AW'(free_end >> WAW);
            set_mode <= 1'b0;
            ptr      <= AW'(div_q >> WAW);
            rd_more  <= 1'b1;
            pend     <= 1'b0;
            state    <= S_MARK;
          end
        end
        S_SCAN: begin
          pend   <= rd_more;
          pend_w <= ptr;
          if (rd_more) begin
            if (ptr == last_w) begin
              rd_more <= 1'b0;
            end else begin
              ptr <= ptr + AW'(1);
            end
          end
          if (pend) begin
            if (hit.found) begin
              lo       <= hit_start;
              hi       <= hit_end;
              last_w   <= pend_w;
              set_mode <= 1'b1;
              ptr      <= hit_start[GW-1:WAW];
              rd_more  <= 1'b1;
              pend     <= 1'b0;
              state    <= S_MARK;
            end else if (pend_w == last_w) begin
              res_status <= cbra_pkg::STATUS_NO_RUN;
              rd_more    <= 1'b0;
              pend       <= 1'b0;
              state      <= S_DONE;
            end else begin
              run <= run_out;
            end
          end
        end
        S_MARK: begin
          pend   <= rd_more;
          pend_w <= ptr;
          if (rd_more) begin
            if (ptr == last_w) begin
              rd_more <= 1'b0;
            end else begin
              ptr <= ptr + AW'(1);
            end
          end
          if (pend && (pend_w == last_w)) begin
            rd_more <= 1'b0;
            pend    <= 1'b0;
            state   <= (action_q == cbra_pkg::ACT_ALLOC) ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          prod  <= lo * REGION_BYTES[RB_W-1:0];
          state <= S_ADD;
        end
        S_ADD: begin
          res_addr <= pool_base + AWD'(prod);
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            region_address <= res_addr;
            status         <= res_status;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/cbra_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module cbra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/cbra_div.sv */
`timescale 1ns / 1ps
// Division by a constant through multiplication by its rounded-up reciprocal, registered once.
// No package dependencies; the quotient is exact for every dividend that fits in DW bits, while it fits in QW bits.
module cbra_div #(
  parameter int DW      = 20,
  parameter int QW      = 11,
  parameter int DIVISOR = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int          SH    = DW + $clog2(DIVISOR);
  localparam int          PW    = 2 * DW + 1;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [PW-1:0] prod;
  logic [PW-1:0] scaled;

  assign prod   = PW'(dividend) * PW'(RECIP[DW:0]);
  assign scaled = prod >> SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= scaled[QW-1:0];
    end
  end

endmodule

/* hw/rtl/cbra_scan.sv */
`timescale 1ns / 1ps
// First-fit evaluation of one bitmap word: run lengths per bit, first bit that completes the run.
// Depends on cbra_pkg for the word width and the hit type.
module cbra_scan #(
  parameter int CNT_W = 11,
  parameter int RUN_W = 17
) (
  input  logic [cbra_pkg::WORD_W-1:0] word,
  input  logic [RUN_W-1:0]            run_in,
  input  logic [CNT_W-1:0]            k,
  output cbra_pkg::scan_hit_t         hit,
  output logic [RUN_W-1:0]            run_out
);

  logic [RUN_W-1:0]            run_at [cbra_pkg::WORD_W];
  logic [cbra_pkg::WORD_W-1:0] reach;

  always_comb begin
    logic has;
    logic [cbra_pkg::WORD_AW-1:0] lu;
    for (int j = 0; j < cbra_pkg::WORD_W; j++) begin
      has = 1'b0;
      lu  = '0;
      for (int i = 0; i <= j; i++) begin
        if (word[i]) begin
          has = 1'b1;
          lu  = cbra_pkg::WORD_AW'(i);
        end
      end
      if (has) begin
        run_at[j] = RUN_W'(cbra_pkg::WORD_AW'(j) - lu);
      end else begin
        run_at[j] = run_in + RUN_W'(j + 1);
      end
      reach[j] = run_at[j] >= RUN_W'(k);
    end
  end

  always_comb begin
    hit = '0;
    for (int j = cbra_pkg::WORD_W - 1; j >= 0; j--) begin
      if (reach[j]) begin
        hit.found = 1'b1;
        hit.pos   = cbra_pkg::WORD_AW'(j);
      end
    end
  end

  assign run_out = run_at[cbra_pkg::WORD_W-1];

endmodule

/* hw/rtl/cbra_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the allocator core, attached to it by the bind at the end.
// Depends on cbra_pkg for the address width and the status codes.
module cbra_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [cbra_pkg::ADDR_W-1:0] region_address,
  input logic                        status
);

  // The clearing pass holds off requests straight after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request side open straight after reset");

  // Only one item is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second item taken while one is in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == cbra_pkg::STATUS_NO_RUN) |-> region_address == '0)
    else $error("failed allocation with a non-zero address");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(region_address) && $stable(status))
    else $error("stalled result changed");

endmodule

bind contiguous_bitmap_region_allocator_core cbra_checker u_cbra_checker (.*);
